/* rtl/fsp_pkg.sv */
// Package for the frame submit pacer: operation and register codes, item and
// decision structures, reset values and constants.
// No dependencies.
package fsp_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [2:0] {
    OP_REQUEST      = 3'd0,
    OP_QUERY        = 3'd1,
    OP_TRY_SUBMIT   = 3'd2,
    OP_MARK_SUBMIT  = 3'd3,
    OP_SET_DEADLINE = 3'd4,
    OP_SET_FLAGS    = 3'd5
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TARGET_FPS   = 2'd0,
    CFG_RESIZE_DEB   = 2'd1,
    CFG_PAUSE_HIDDEN = 2'd2
  } cfg_idx_e;

  // Default values of the reason count and the configurable bit positions.
  localparam int unsigned NumReasonsDef   = 8;
  localparam int unsigned ResizeBitDef    = 1;
  localparam int unsigned AnimationBitDef = 2;

  // Window flag bit positions.
  localparam int unsigned FlAnim   = 0;
  localparam int unsigned FlVis    = 1;
  localparam int unsigned FlVsync  = 2;
  localparam int unsigned FlReduce = 3;

  // Reset values.
  localparam logic [3:0]  FlagsReset      = 4'b0110;
  localparam logic [9:0]  IntervalReset   = 10'd16;
  localparam logic [31:0] DebounceReset   = 32'd0;
  localparam logic        PauseHiddenRst  = 1'b1;

  // Interval divider: milliseconds per second as dividend, one bit per step.
  localparam logic [9:0]  MsPerS   = 10'd1000;
  localparam logic [3:0]  DivSteps = 4'd10;

  // One input item.
  typedef struct packed {
    op_e         op;
    logic [63:0] now_ms;
    logic [2:0]  reason;
    logic        deadline_valid;
    logic [63:0] deadline_ms;
    logic        animations_active;
    logic        window_visible;
    logic        vsync_on;
    logic        reduce_motion;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        submit;
    logic        paused_hidden;
    logic        deferred_resize;
    logic [7:0]  reasons;
    logic        wait_valid;
    logic [31:0] wait_ms;
    logic [31:0] frames_submitted;
  } decision_t;

endpackage

/* rtl/fsp_div.sv */
// Frame interval divider: computes 1000 / target_fps one quotient bit per cycle
// after a target rate write. Depends on fsp_pkg.
module fsp_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [9:0] fps_i,
  output logic       busy_o,
  output logic [9:0] interval_o
);

  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [9:0] divisor_q, divisor_d;
  logic [9:0] rem_q, rem_d;
  logic [9:0] quo_q, quo_d;
  logic [9:0] interval_q, interval_d;
  logic [10:0] rem_sh;
  logic        ge;

  // Shift in the next dividend bit and try the subtraction.
  assign rem_sh = {rem_q, fsp_pkg::MsPerS[cnt_q - 4'd1]};
  assign ge     = rem_sh >= {1'b0, divisor_q};

  always_comb begin
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    divisor_d  = divisor_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    interval_d = interval_q;
    if (start_i) begin
      // A zero rate disables throttling right away.
      if (fps_i == 10'd0) begin
        interval_d = 10'd0;
        busy_d     = 1'b0;
      end else begin
        busy_d    = 1'b1;
        cnt_d     = fsp_pkg::DivSteps;
        divisor_d = fps_i;
        rem_d     = 10'd0;
        quo_d     = 10'd0;
      end
    end else if (busy_q) begin
      rem_d = ge ? 10'(rem_sh - {1'b0, divisor_q}) : rem_sh[9:0];
      quo_d = {quo_q[8:0], ge};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d     = 1'b0;
        interval_d = {quo_q[8:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= 4'd0;
      interval_q <= fsp_pkg::IntervalReset;
    end else begin
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      interval_q <= interval_d;
    end
  end

  // Datapath registers of the division.
  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
  end

  assign busy_o     = busy_q;
  assign interval_o = interval_q;

endmodule

/* rtl/fsp_core.sv */
// Pacer state and frame decision: applies one item to the state, evaluates
// the decision and consumes it on a granted try-submit. Depends on fsp_pkg.
module fsp_core #(
  parameter int unsigned NUM_REASONS   = fsp_pkg::NumReasonsDef,
  parameter int unsigned RESIZE_BIT    = fsp_pkg::ResizeBitDef,
  parameter int unsigned ANIMATION_BIT = fsp_pkg::AnimationBitDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  fsp_pkg::item_t      item_i,
  input  logic [31:0]         debounce_i,
  input  logic                pause_hidden_i,
  input  logic [9:0]          interval_i,
  output fsp_pkg::decision_t  dec_o
);

  localparam logic [31:0] ResizeBit32 =
    (RESIZE_BIT < NUM_REASONS) ? (32'd1 << RESIZE_BIT) : 32'd0;
  localparam logic [31:0] AnimBit32 =
    (ANIMATION_BIT < NUM_REASONS) ? (32'd1 << ANIMATION_BIT) : 32'd0;
  localparam logic [NUM_REASONS-1:0] ResizeMask = NUM_REASONS'(ResizeBit32);

  logic [NUM_REASONS-1:0] pend_q, pend_d, p_pend;
  logic                   rs_q, rs_d, p_rs;
  logic [63:0]            rt_q, rt_d, p_rt;
  logic [63:0]            st_q, st_d, p_st;
  logic                   so_q, so_d, p_so;
  logic                   wv_q, wv_d, p_wv;
  logic [63:0]            wt_q, wt_d, p_wt;
  logic [3:0]             fl_q, fl_d, p_fl;
  logic [31:0]            fc_q, fc_d, p_fc;

  logic               anim, has_pend, other_pend;
  logic [63:0]        since_r, since_s, to_wake;
  logic               wake_ahead;
  logic [31:0]        remain;
  logic [31:0]        pend32;
  fsp_pkg::decision_t dec;

  // State as seen after this item's own update.
  always_comb begin
    p_pend = pend_q;
    p_rs   = rs_q;
    p_rt   = rt_q;
    p_st   = st_q;
    p_so   = so_q;
    p_wv   = wv_q;
    p_wt   = wt_q;
    p_fl   = fl_q;
    p_fc   = fc_q;
    case (item_i.op)
      fsp_pkg::OP_REQUEST: begin
        if (32'(item_i.reason) < NUM_REASONS) begin
          p_pend = pend_q | NUM_REASONS'(32'd1 << item_i.reason);
          if (32'(item_i.reason) == RESIZE_BIT) begin
            p_rt = item_i.now_ms;
            p_rs = 1'b1;
          end
        end
      end
      fsp_pkg::OP_MARK_SUBMIT: begin
        p_st = item_i.now_ms;
        p_so = 1'b1;
        p_fc = fc_q + 32'd1;
      end
      fsp_pkg::OP_SET_DEADLINE: begin
        p_wv = item_i.deadline_valid;
        p_wt = item_i.deadline_ms;
      end
      fsp_pkg::OP_SET_FLAGS: begin
        p_fl = {item_i.reduce_motion, item_i.vsync_on,
                item_i.window_visible, item_i.animations_active};
      end
      default: ;
    endcase
  end

  // Time differences and conditions for the decision.
  assign anim       = p_fl[fsp_pkg::FlAnim] & ~p_fl[fsp_pkg::FlReduce];
  assign has_pend   = |p_pend;
  assign other_pend = |(p_pend & ~ResizeMask);
  assign since_r    = item_i.now_ms - p_rt;
  assign since_s    = item_i.now_ms - p_st;
  assign to_wake    = p_wt - item_i.now_ms;
  assign wake_ahead = item_i.now_ms < p_wt;
  assign remain     = 32'(interval_i - since_s[9:0]);
  assign pend32     = 32'(p_pend);

  // Decision in priority order: hidden, resize debounce, throttle, submit, wake.
  always_comb begin
    dec                  = '0;
    dec.frames_submitted = p_fc;
    if (!p_fl[fsp_pkg::FlVis] && pause_hidden_i) begin
      dec.paused_hidden = 1'b1;
    end else if (has_pend && !other_pend && p_rs && (since_r < 64'(debounce_i))) begin
      dec.deferred_resize = 1'b1;
      dec.reasons         = pend32[7:0];
      dec.wait_valid      = 1'b1;
      dec.wait_ms         = debounce_i - since_r[31:0];
    end else if (p_so && p_fl[fsp_pkg::FlVsync] && (interval_i != 10'd0) &&
                 (since_s < 64'(interval_i))) begin
      if (has_pend || anim) begin
        dec.reasons    = pend32[7:0];
        dec.wait_valid = 1'b1;
        dec.wait_ms    = remain;
      end else if (p_wv && wake_ahead) begin
        dec.wait_valid = 1'b1;
        dec.wait_ms    = (to_wake < 64'(remain)) ? to_wake[31:0] : remain;
      end
    end else if (has_pend) begin
      dec.submit     = 1'b1;
      dec.reasons    = pend32[7:0];
      dec.wait_valid = 1'b1;
    end else if (anim || (p_wv && !wake_ahead)) begin
      dec.submit     = 1'b1;
      dec.reasons    = AnimBit32[7:0];
      dec.wait_valid = 1'b1;
    end else if (p_wv) begin
      dec.wait_valid = 1'b1;
      dec.wait_ms    = (|to_wake[63:32]) ? 32'hFFFF_FFFF : to_wake[31:0];
    end
  end

  // A granted try-submit consumes the pending reasons and the deadline.
  always_comb begin
    pend_d = p_pend;
    rs_d   = p_rs;
    rt_d   = p_rt;
    st_d   = p_st;
    so_d   = p_so;
    wv_d   = p_wv;
    wt_d   = p_wt;
    fl_d   = p_fl;
    fc_d   = p_fc;
    if ((item_i.op == fsp_pkg::OP_TRY_SUBMIT) && dec.submit) begin
      pend_d = '0;
      wv_d   = 1'b0;
      if (|(p_pend & ResizeMask)) begin
        rs_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      rs_q   <= 1'b0;
      rt_q   <= 64'd0;
      st_q   <= 64'd0;
      so_q   <= 1'b0;
      wv_q   <= 1'b0;
      wt_q   <= 64'd0;
      fl_q   <= fsp_pkg::FlagsReset;
      fc_q   <= 32'd0;
    end else if (en_i) begin
      pend_q <= pend_d;
      rs_q   <= rs_d;
      rt_q   <= rt_d;
      st_q   <= st_d;
      so_q   <= so_d;
      wv_q   <= wv_d;
      wt_q   <= wt_d;
      fl_q   <= fl_d;
      fc_q   <= fc_d;
    end
  end

  assign dec_o = dec;

endmodule

/* rtl/frame_submit_pacer.sv */
// Frame submit pacer top level: input register, pacer core, result register,
// configuration registers and interval divider. Depends on fsp_pkg, fsp_div, fsp_core.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_ready_o   op_i .. reduce_motion_i
//   out       source     out_valid_o / out_ready_i submit_o .. frames_submitted_o
//   cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item passes through the input register and then through the decision
// logic into the result register. A new item can be taken every cycle while
// the output is not stalled and the divider is idle; a stalled output holds
// both registers. A target rate write starts the interval divider, which
// finds the quotient bit by bit; items and writes wait while it runs.
// Reset restores the default rate (interval 16 ms), flags and empty state.
module frame_submit_pacer #(
  parameter int unsigned NUM_REASONS   = fsp_pkg::NumReasonsDef,
  parameter int unsigned RESIZE_BIT    = fsp_pkg::ResizeBitDef,
  parameter int unsigned ANIMATION_BIT = fsp_pkg::AnimationBitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] now_ms_i,
  input  logic [2:0]  reason_i,
  input  logic        deadline_valid_i,
  input  logic [63:0] deadline_ms_i,
  input  logic        animations_active_i,
  input  logic        window_visible_i,
  input  logic        vsync_on_i,
  input  logic        reduce_motion_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        submit_o,
  output logic        paused_hidden_o,
  output logic        deferred_resize_o,
  output logic [7:0]  reasons_o,
  output logic        wait_valid_o,
  output logic [31:0] wait_ms_o,
  output logic [31:0] frames_submitted_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic               s1_valid_q, s1_valid_d;
  fsp_pkg::item_t     s1_item_q, in_item;
  logic               out_valid_q, out_valid_d;
  fsp_pkg::decision_t out_q, dec;
  logic               advance, in_xfer, cfg_xfer;
  logic               div_busy, div_start;
  logic [9:0]         interval;
  logic [31:0]        debounce_q, debounce_d;
  logic               pause_q, pause_d;

  // Handshakes: the item in the input register moves on when the result
  // register is free or being emptied.
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !div_busy && (!s1_valid_q || advance);
  assign cfg_ready_o = !div_busy;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  assign in_item = '{
    op:                fsp_pkg::op_e'(op_i),
    now_ms:            now_ms_i,
    reason:            reason_i,
    deadline_valid:    deadline_valid_i,
    deadline_ms:       deadline_ms_i,
    animations_active: animations_active_i,
    window_visible:    window_visible_i,
    vsync_on:          vsync_on_i,
    reduce_motion:     reduce_motion_i
  };

  // Valid flags of the input and result registers.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  // Configuration registers other than the target rate, and the divider start on a target rate write.
  always_comb begin
    debounce_d = debounce_q;
    pause_d    = pause_q;
    div_start  = 1'b0;
    if (cfg_xfer) begin
      case (fsp_pkg::cfg_idx_e'(cfg_index_i))
        fsp_pkg::CFG_TARGET_FPS:   div_start  = 1'b1;
        fsp_pkg::CFG_RESIZE_DEB:   debounce_d = cfg_data_i;
        fsp_pkg::CFG_PAUSE_HIDDEN: pause_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      debounce_q  <= fsp_pkg::DebounceReset;
      pause_q     <= fsp_pkg::PauseHiddenRst;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      debounce_q  <= debounce_d;
      pause_q     <= pause_d;
    end
  end

  // Payload registers on both sides of the decision logic.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item;
    end
    if (advance) begin
      out_q <= dec;
    end
  end

  fsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .fps_i      (cfg_data_i[9:0]),
    .busy_o     (div_busy),
    .interval_o (interval)
  );

  fsp_core #(
    .NUM_REASONS   (NUM_REASONS),
    .RESIZE_BIT    (RESIZE_BIT),
    .ANIMATION_BIT (ANIMATION_BIT)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .item_i         (s1_item_q),
    .debounce_i     (debounce_q),
    .pause_hidden_i (pause_q),
    .interval_i     (interval),
    .dec_o          (dec)
  );

  assign out_valid_o        = out_valid_q;
  assign submit_o           = out_q.submit;
  assign paused_hidden_o    = out_q.paused_hidden;
  assign deferred_resize_o  = out_q.deferred_resize;
  assign reasons_o          = out_q.reasons;
  assign wait_valid_o       = out_q.wait_valid;
  assign wait_ms_o          = out_q.wait_ms;
  assign frames_submitted_o = out_q.frames_submitted;

`ifndef NO_ASSERTIONS
  // No item transfer while the interval divider is running.
  a_no_item_while_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !in_ready_o)
    else $error("item taken while interval divider busy");

  // A submit decision is never paused or deferred.
  a_submit_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && submit_o) |-> (!paused_hidden_o && !deferred_resize_o))
    else $error("submit together with pause or deferral");

  // A paused decision carries no reasons and no wait time.
  a_paused_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && paused_hidden_o) |-> (reasons_o == 8'd0 && !wait_valid_o))
    else $error("paused decision carries reasons or wait");

  // An indefinite wait reports zero milliseconds.
  a_wait_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !wait_valid_o) |-> (wait_ms_o == 32'd0))
    else $error("indefinite wait with nonzero wait time");

  // The item register drains into the result register on the next cycle when free.
  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("item did not reach result register");
`endif

endmodule
